// ----- src/mpba_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpba_pkg: shared types and codes for the multi-pool block allocator
// Action and status codes, register map sizes and the fixed pool geometry.
// ----------------------------------------------------------------------------
package mpba_pkg;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_BUILD = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SIZE_ZERO = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_NOT_POOL  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned SIZE_REGS = 4;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned CNT_REG_W = 7;
  localparam int unsigned REG_IDX_W = 3;

  // pool geometry, tied to the port widths and the register map
  localparam int unsigned POOLS      = 4;
  localparam int unsigned MAX_BLOCKS = 64;
  localparam int unsigned ADDR_BITS  = 24;

endpackage
`default_nettype wire

// ----- src/mpba_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpba_ram: generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module mpba_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- src/multi_pool_block_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_pool_block_allocator: fixed-block pool allocator with LIFO free lists
// One item at a time: busy rises on start and result strobe ends the item.
// ----------------------------------------------------------------------------
// Allocate scans the pools, one pool compared a cycle, then reads the stack
// RAM and captures the read data; free runs the same pool scan, then one
// stack RAM write; a no-op or zero-size allocate goes straight to the result.
// Build writes one block address a cycle through the single RAM port, closes
// each pool whose count is below MAX_BLOCKS in a step of its own, and then
// posts the result. The free stacks live in one single-port RAM, which sets
// the per-item cost. The result is shown for one cycle on result_valid and
// cannot be stalled.
// ----------------------------------------------------------------------------
module multi_pool_block_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    action,
  input  wire logic [15:0]                   req_size,
  input  wire logic [23:0]                   block_addr,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mpba_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data,
  output logic                               result_valid,
  output logic [2:0]                         status,
  output logic [1:0]                         pool,
  output logic [23:0]                        granted_addr,
  output logic [6:0]                         free_left
);

  localparam int unsigned POOLS      = mpba_pkg::POOLS;
  localparam int unsigned MAX_BLOCKS = mpba_pkg::MAX_BLOCKS;
  localparam int unsigned ADDR_BITS  = mpba_pkg::ADDR_BITS;
  localparam int unsigned PW    = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int unsigned BW    = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned KW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned DEPTH = POOLS * MAX_BLOCKS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WW    = 48;  // wide address math, never wraps
  localparam int unsigned SW    = 16 + BW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_DONE, S_BUILD, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] bsize [POOLS];
  logic [6:0]  bcount [POOLS];
  logic [BW-1:0] fcount [POOLS];
  logic built;

  // latched item
  mpba_pkg::action_t act;
  logic [15:0] req;
  logic [23:0] addr;

  // scan state
  logic [PW-1:0] p;
  logic [WW-1:0] base;
  logic found;
  logic [PW-1:0] best;
  logic [15:0] bsz;
  logic [KW-1:0] k;
  logic [WW-1:0] baddr;

  // ram port
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [ADDR_BITS-1:0] ram_wdata, ram_rdata;

  mpba_ram #(.WIDTH(ADDR_BITS), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign cfg_ready = (state == S_IDLE);
  assign busy      = (state != S_IDLE);

  // effective (saturated) count of the scanned pool and its end address
  logic [BW-1:0] eff_p;
  logic [SW-1:0] span_p;
  logic [WW-1:0] end_p;
  logic [BW-1:0] eff_best;
  always_comb begin
    eff_p = (bcount[p] > 7'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : BW'(bcount[p]);
    eff_best = (bcount[best] > 7'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : BW'(bcount[best]);
    span_p = SW'(bsize[p]) * SW'(eff_p);
    end_p = base + WW'(span_p);
  end

  logic [AW-1:0] slot_best;
  assign slot_best = AW'(best) * AW'(MAX_BLOCKS);

  // drive the RAM port from the sequencer state
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_best + AW'(fcount[best] - 1'b1);
    ram_wdata = ADDR_BITS'(addr);
    if (state == S_READ && act == mpba_pkg::ACT_FREE) begin
      ram_we   = (fcount[best] < eff_best);
      ram_addr = slot_best + AW'(fcount[best]);
    end else if (state == S_BUILD) begin
      ram_we    = (BW'(k) < eff_p);
      ram_addr  = AW'(AW'(p) * AW'(MAX_BLOCKS)) + AW'(eff_p - BW'(1) - BW'(k));
      ram_wdata = ADDR_BITS'(baddr);
    end
  end

  logic last_p;
  assign last_p = (p == PW'(POOLS - 1));

  // sequencer, counts and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      built <= 1'b0;
      for (int i = 0; i < POOLS; i++) begin
        fcount[i] <= '0;
        bsize[i]  <= (i == 0) ? 16'd16 : (i == 1) ? 16'd64 :
                     (i == 2) ? 16'd256 : (i == 3) ? 16'd1024 : 16'd0;
        bcount[i] <= (i < 4) ? 7'd32 : 7'd0;
      end
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            for (int i = 0; i < POOLS; i++) begin
              if (cfg_index == mpba_pkg::REG_IDX_W'(i)) bsize[i] <= cfg_data;
              if (cfg_index == mpba_pkg::REG_IDX_W'(i + 4)) bcount[i] <= cfg_data[6:0];
            end
          end
          if (start) begin
            act <= mpba_pkg::action_t'(action);
            req <= req_size;
            addr <= block_addr;
            p <= '0; base <= '0; found <= 1'b0; best <= '0; bsz <= '0; k <= '0;
            baddr <= '0;
            status <= mpba_pkg::ST_OK; pool <= '0; granted_addr <= '0; free_left <= '0;
            if (action == mpba_pkg::ACT_BUILD) state <= S_BUILD;
            else if (action == mpba_pkg::ACT_NONE) state <= S_OUT;
            else if (action == mpba_pkg::ACT_ALLOC && req_size == 16'd0) begin
              status <= mpba_pkg::ST_SIZE_ZERO;
              state <= S_OUT;
            end else state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // examine one pool a cycle
          if (act == mpba_pkg::ACT_ALLOC) begin
            if (req <= bsize[p] && fcount[p] != '0 && (!found || bsize[p] < bsz)) begin
              found <= 1'b1; best <= p; bsz <= bsize[p];
            end
          end else if (built && !found && WW'(addr) >= base && WW'(addr) < end_p) begin
            found <= 1'b1; best <= p;
          end
          base <= end_p;
          p <= p + 1'b1;
          if (last_p) state <= S_READ;
        end
        S_READ: begin
          if (act == mpba_pkg::ACT_ALLOC) begin
            if (!found) begin
              status <= mpba_pkg::ST_NO_FIT;
              state <= S_OUT;
            end else begin
              fcount[best] <= fcount[best] - 1'b1;
              pool <= 2'(best);
              free_left <= 7'(fcount[best] - 1'b1);
              state <= S_DONE;
            end
          end else begin
            if (!found) status <= mpba_pkg::ST_NOT_POOL;
            else begin
              pool <= 2'(best);
              if (fcount[best] >= eff_best) begin
                status <= mpba_pkg::ST_FULL;
                free_left <= 7'(fcount[best]);
              end else begin
                fcount[best] <= fcount[best] + 1'b1;
                free_left <= 7'(fcount[best] + 1'b1);
              end
            end
            state <= S_OUT;
          end
        end
        S_DONE: begin
          granted_addr <= 24'(ram_rdata);
          state <= S_OUT;
        end
        S_BUILD: begin
          // write one block address a cycle, then move to next pool
          if (BW'(k) < eff_p && k != KW'(MAX_BLOCKS - 1)) begin
            k <= k + 1'b1;
            baddr <= baddr + WW'(bsize[p]);
          end else begin
            fcount[p] <= eff_p;
            k <= '0;
            base <= end_p;
            baddr <= end_p;
            p <= p + 1'b1;
            if (last_p) begin
              built <= 1'b1;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          result_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/mpba_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpba_checker: port-level checks for the block allocator
// Watches start, busy and result timing.
// ----------------------------------------------------------------------------
module mpba_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       result_valid,
  input wire logic [2:0] status,
  input wire logic [23:0] granted_addr
);

  // a transfer raises busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");

  // result only ends a busy item
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without item");

  // result drops busy
  a_res_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("busy after result");

  // failed statuses grant nothing
  a_grant: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != mpba_pkg::ST_OK |-> granted_addr == 24'd0)
    else $error("grant on failure");

endmodule

bind multi_pool_block_allocator mpba_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .result_valid(result_valid),
  .status(status), .granted_addr(granted_addr)
);
`default_nettype wire
